### hdl/stbr_pkg.sv
// Shared types and constants for the smoothed triple bar renderer.
// No dependencies; every other file in hdl/ refers to it by scoped names.
`timescale 1ns / 1ps

package stbr_pkg;

  // Display geometry default and queue size
  localparam int NUM_COLUMNS_DEF = 25;
  localparam int QUEUE_DEPTH     = 2;

  // Field widths
  localparam int PCT_W   = 16;
  localparam int WIDE_W  = 14;  // CPU / RAM level, Q8, 0..50
  localparam int NARROW_W = 13; // GPU level, Q8, 0..25
  localparam int WSTEP_W = 6;   // rounded CPU / RAM step count, 0..50
  localparam int NSTEP_W = 5;   // rounded GPU step count, 0..25
  localparam int IDX_W   = 5;
  localparam int BITS_W  = 7;

  // Limits, Q8
  localparam logic [PCT_W-1:0]   PCT_MAX    = 16'd25600;
  localparam logic [WIDE_W-1:0]  WIDE_MAX   = 14'd12800;
  localparam logic [WIDE_W-1:0]  NARROW_MAX = 14'd6400;

  // Row masks
  localparam logic [BITS_W-1:0] CPU_FULL = 7'h60;
  localparam logic [BITS_W-1:0] CPU_PART = 7'h20;
  localparam logic [BITS_W-1:0] RAM_FULL = 7'h0c;
  localparam logic [BITS_W-1:0] RAM_PART = 7'h04;
  localparam logic [BITS_W-1:0] GPU_BIT  = 7'h01;

  // One set of smoothed levels, passed from front to back
  typedef struct packed {
    logic [WIDE_W-1:0]   cpu;
    logic [WIDE_W-1:0]   ram;
    logic [NARROW_W-1:0] gpu;
  } levels_t;

endpackage

### hdl/stbr_front.sv
// Front end: takes percent words, saturates them into targets and smooths
// the three levels. Depends on stbr_pkg.
`timescale 1ns / 1ps

module stbr_front (
  input  logic                  clk,
  input  logic                  rst,
  // word from the input channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [stbr_pkg::PCT_W-1:0] cpu_percent,
  input  logic [stbr_pkg::PCT_W-1:0] ram_percent,
  input  logic [stbr_pkg::PCT_W-1:0] gpu_percent,
  // push side of the queue
  output logic                  push,
  input  logic                  push_ready,
  output stbr_pkg::levels_t     push_data
);

  // Move a level toward its target by about 0.3 of the gap, snapping
  // when the gap is at most one step. Arithmetic shift floors.
  function automatic logic [stbr_pkg::WIDE_W-1:0] smooth(
    input logic [stbr_pkg::WIDE_W-1:0] level,
    input logic [stbr_pkg::WIDE_W-1:0] target,
    input logic [stbr_pkg::WIDE_W-1:0] max_level
  );
    logic signed [15:0] d;
    logic signed [22:0] prod;
    logic signed [15:0] sum;
    logic [stbr_pkg::WIDE_W-1:0] res;
    d    = $signed({2'b00, target}) - $signed({2'b00, level});
    prod = 23'(d) * $signed(23'd77);
    sum  = $signed({2'b00, level}) + 16'($signed(prod[22:8]));
    if (d > 16'sd256 || d < -16'sd256) begin
      if (sum < 16'sd0) begin
        res = '0;
      end else if (sum[stbr_pkg::WIDE_W-1:0] > max_level) begin
        res = max_level;
      end else begin
        res = sum[stbr_pkg::WIDE_W-1:0];
      end
    end else begin
      res = target;
    end
    return res;
  endfunction

  logic [stbr_pkg::PCT_W-1:0] cpu_sat, ram_sat, gpu_sat;
  logic                        tgt_valid;
  logic [stbr_pkg::WIDE_W-1:0]   cpu_tgt, ram_tgt;
  logic [stbr_pkg::NARROW_W-1:0] gpu_tgt;
  logic [stbr_pkg::WIDE_W-1:0]   cpu_level, ram_level;
  logic [stbr_pkg::NARROW_W-1:0] gpu_level;
  logic [stbr_pkg::WIDE_W-1:0]   gpu_wide_next;
  stbr_pkg::levels_t             levels_next;

  // Saturate at 100 percent
  assign cpu_sat = (cpu_percent > stbr_pkg::PCT_MAX) ? stbr_pkg::PCT_MAX : cpu_percent;
  assign ram_sat = (ram_percent > stbr_pkg::PCT_MAX) ? stbr_pkg::PCT_MAX : ram_percent;
  assign gpu_sat = (gpu_percent > stbr_pkg::PCT_MAX) ? stbr_pkg::PCT_MAX : gpu_percent;

  assign in_ready = !tgt_valid || push_ready;
  assign push     = tgt_valid && push_ready;

  // Target register: halve CPU / RAM, quarter GPU
  always_ff @(posedge clk) begin
    if (rst) begin
      tgt_valid <= 1'b0;
    end else if (in_ready) begin
      tgt_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      cpu_tgt <= cpu_sat[stbr_pkg::PCT_W-2:1];
      ram_tgt <= ram_sat[stbr_pkg::PCT_W-2:1];
      gpu_tgt <= gpu_sat[stbr_pkg::NARROW_W+1:2];
    end
  end

  // Smoothing step
  assign gpu_wide_next = smooth({1'b0, gpu_level}, {1'b0, gpu_tgt}, stbr_pkg::NARROW_MAX);
  always_comb begin
    levels_next.cpu = smooth(cpu_level, cpu_tgt, stbr_pkg::WIDE_MAX);
    levels_next.ram = smooth(ram_level, ram_tgt, stbr_pkg::WIDE_MAX);
    levels_next.gpu = gpu_wide_next[stbr_pkg::NARROW_W-1:0];
  end
  assign push_data = levels_next;

  // Level state
  always_ff @(posedge clk) begin
    if (rst) begin
      cpu_level <= '0;
      ram_level <= '0;
      gpu_level <= '0;
    end else if (push) begin
      cpu_level <= levels_next.cpu;
      ram_level <= levels_next.ram;
      gpu_level <= levels_next.gpu;
    end
  end

  // Levels stay inside their scales
  a_cpu_range: assert property (@(posedge clk) disable iff (rst)
    cpu_level <= stbr_pkg::WIDE_MAX && ram_level <= stbr_pkg::WIDE_MAX)
    else $error("cpu/ram level out of range");
  a_gpu_range: assert property (@(posedge clk) disable iff (rst)
    {1'b0, gpu_level} <= stbr_pkg::NARROW_MAX)
    else $error("gpu level out of range");
  a_push_holds: assert property (@(posedge clk) disable iff (rst)
    (tgt_valid && !push_ready) |=> tgt_valid && $stable(cpu_tgt) && $stable(gpu_tgt))
    else $error("pending target lost while queue full");

endmodule

### hdl/stbr_queue.sv
// Short queue of smoothed level sets between front and back.
// Depends on stbr_pkg.
`timescale 1ns / 1ps

module stbr_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              push_ready,
  input  stbr_pkg::levels_t push_data,
  input  logic              pop,
  output logic              pop_valid,
  output stbr_pkg::levels_t pop_data
);

  localparam int DEPTH = stbr_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  stbr_pkg::levels_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign push_ready = count != CNT_W'(DEPTH);
  assign pop_valid  = count != '0;
  assign pop_data   = entries[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (push_ready || pop))
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> pop_valid)
    else $error("pop from empty queue");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

endmodule

### hdl/stbr_back.sv
// Back end: turns one level set into a frame of column words, one column per
// cycle unless out_ready stalls, through an output register. Depends on stbr_pkg.
`timescale 1ns / 1ps

module stbr_back #(
  parameter int NUM_COLUMNS = stbr_pkg::NUM_COLUMNS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  output logic              pop,
  input  stbr_pkg::levels_t q_data,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [stbr_pkg::IDX_W-1:0]  column_index,
  output logic [stbr_pkg::BITS_W-1:0] column_bits,
  output logic              last_column
);

  localparam int COL_W = $clog2(NUM_COLUMNS);

  logic                         busy;
  logic [COL_W-1:0]             col;
  logic [COL_W-1:0]             pos;
  logic [stbr_pkg::WSTEP_W-1:0] lc, lr;
  logic [stbr_pkg::NSTEP_W-1:0] lg;
  logic [stbr_pkg::WIDE_W:0]    cpu_r, ram_r;
  logic [stbr_pkg::NARROW_W:0]  gpu_r;
  logic [6:0]                   pos_x, fill_c, fill_r, lg_x;
  logic [stbr_pkg::BITS_W-1:0]  cpu_m, ram_m, gpu_m;
  logic                         adv, at_last;

  // Rounded step counts of the incoming level set
  assign cpu_r = {1'b0, q_data.cpu} + (stbr_pkg::WIDE_W+1)'(128);
  assign ram_r = {1'b0, q_data.ram} + (stbr_pkg::WIDE_W+1)'(128);
  assign gpu_r = {1'b0, q_data.gpu} + (stbr_pkg::NARROW_W+1)'(128);

  assign adv     = !out_valid || out_ready;
  assign at_last = col == COL_W'(NUM_COLUMNS - 1);
  assign pop     = q_valid && (!busy || (adv && at_last));

  // Column masks; pos counts from the right edge
  assign pos    = COL_W'(NUM_COLUMNS - 1) - col;
  assign pos_x  = 7'(pos);
  assign fill_c = 7'(lc[stbr_pkg::WSTEP_W-1:1]);
  assign fill_r = 7'(lr[stbr_pkg::WSTEP_W-1:1]);
  assign lg_x   = 7'(lg);

  always_comb begin
    if (pos_x < fill_c) begin
      cpu_m = stbr_pkg::CPU_FULL;
    end else if (pos_x == fill_c && lc[0]) begin
      cpu_m = stbr_pkg::CPU_PART;
    end else begin
      cpu_m = '0;
    end
    if (pos_x < fill_r) begin
      ram_m = stbr_pkg::RAM_FULL;
    end else if (pos_x == fill_r && lr[0]) begin
      ram_m = stbr_pkg::RAM_PART;
    end else begin
      ram_m = '0;
    end
    gpu_m = (pos_x < lg_x) ? stbr_pkg::GPU_BIT : '0;
  end

  // Frame sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      col       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (adv) begin
        out_valid <= busy;
      end
      if (busy && adv) begin
        col <= at_last ? '0 : col + 1'b1;
      end
      if (pop) begin
        busy <= 1'b1;
      end else if (busy && adv && at_last) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy && adv) begin
      column_index <= stbr_pkg::IDX_W'(col);
      column_bits  <= cpu_m | ram_m | gpu_m;
      last_column  <= at_last;
    end
    if (pop) begin
      lc <= cpu_r[stbr_pkg::WIDE_W-1:8];
      lr <= ram_r[stbr_pkg::WIDE_W-1:8];
      lg <= gpu_r[stbr_pkg::NARROW_W-1:8];
    end
  end

  a_last_index: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last_column) |-> column_index == stbr_pkg::IDX_W'(NUM_COLUMNS - 1))
    else $error("last column flag on wrong column");
  a_col_idle: assert property (@(posedge clk) disable iff (rst)
    !busy |-> col == '0)
    else $error("column counter not parked while idle");
  a_pop_frame: assert property (@(posedge clk) disable iff (rst)
    (pop && busy) |-> at_last && adv)
    else $error("frame cut short by new level set");

endmodule

### hdl/smoothed_triple_bar_renderer_top.sv
// Top level of the smoothed triple bar renderer: front, queue and back.
// Depends on stbr_pkg, stbr_front, stbr_queue, stbr_back.
`timescale 1ns / 1ps

// Usage:
//  Input channel s_*: one word per tick carries CPU, RAM and GPU utilisation
//  in percent with 8 fraction bits. Each accepted word updates the three
//  smoothed levels and produces one frame of NUM_COLUMNS column words on the
//  output channel m_*, leftmost column first, tlast on the rightmost column.
//  Path: the first column of a frame reaches the output register after its
//  input word is accepted, through the level update into the queue, the step
//  counts and the output register, when the back end is idle.
//  Throughput: the back end's column counter emits one column per cycle
//  while m_tready does not stall the output; frames follow each other with
//  no gap when the next level set is already queued.
//  Reset (rst, synchronous) clears the levels to zero, empties the queue and
//  drops any frame in flight.
//  Stall: when m_tready is low the output word holds; the two-entry queue
//  and the target register then fill and s_tready drops until the back end
//  frees an entry.
module smoothed_triple_bar_renderer_top #(
  parameter int NUM_COLUMNS = stbr_pkg::NUM_COLUMNS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // cpu_percent[15:0], ram_percent[31:16], gpu_percent[47:32]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // column_index[4:0], column_bits[11:5], zero[15:12]
  output logic        m_tlast    // last_column
);

  logic              push, push_ready, pop, q_valid;
  stbr_pkg::levels_t push_data, q_data;
  logic [stbr_pkg::IDX_W-1:0]  column_index;
  logic [stbr_pkg::BITS_W-1:0] column_bits;

  stbr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .cpu_percent(s_tdata[15:0]),
    .ram_percent(s_tdata[31:16]),
    .gpu_percent(s_tdata[47:32]),
    .push       (push),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  stbr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_ready(push_ready),
    .push_data (push_data),
    .pop       (pop),
    .pop_valid (q_valid),
    .pop_data  (q_data)
  );

  stbr_back #(
    .NUM_COLUMNS(NUM_COLUMNS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .pop         (pop),
    .q_data      (q_data),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .column_index(column_index),
    .column_bits (column_bits),
    .last_column (m_tlast)
  );

  assign m_tdata = {4'b0000, column_bits, column_index};

endmodule

### verif/smoothed_triple_bar_renderer_top_test.sv
// Self-checking bench for smoothed_triple_bar_renderer_top: a short table of ticks,
// then random ticks, each frame checked column by column against a local predictor.
// Depends on stbr_pkg and the hdl/ sources of the renderer.
`timescale 1ns / 1ps

module smoothed_triple_bar_renderer_top_test;

  localparam int NCOL = stbr_pkg::NUM_COLUMNS_DEF;
  localparam int RANDOM_TICKS = 345;
  localparam int FLUSH_CYCLES = 20;
  localparam int TABLE_ROWS = 25;

  // One expected output word
  typedef struct packed {
    logic [stbr_pkg::IDX_W-1:0]  idx;
    logic [stbr_pkg::BITS_W-1:0] bits;
    logic                        last;
  } column_t;

  // One tick of stimulus; step counts are used only where known is set
  typedef struct packed {
    logic [stbr_pkg::PCT_W-1:0]   cpu;
    logic [stbr_pkg::PCT_W-1:0]   ram;
    logic [stbr_pkg::PCT_W-1:0]   gpu;
    logic                         known;
    logic [stbr_pkg::WSTEP_W-1:0] cpu_steps;
    logic [stbr_pkg::WSTEP_W-1:0] ram_steps;
    logic [stbr_pkg::NSTEP_W-1:0] gpu_steps;
  } tick_row_t;

  typedef enum int {READY_ALWAYS, READY_COIN, READY_MOSTLY, READY_PERIODIC} stall_mode_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        m_tlast;

  // Predictor state: smoothed levels, Q8
  int cpu_lvl = 0;
  int ram_lvl = 0;
  int gpu_lvl = 0;
  column_t pending_columns[$];
  column_t want_col;
  int errors = 0;
  int burst_left = 0;
  stall_mode_t stall_mode = READY_ALWAYS;
  int mode_left = 0;

  // Directed ticks. Rows 3..14 all saturate, so the levels reach full scale by row 14.
  tick_row_t tick_table [0:TABLE_ROWS-1] = '{
    '{16'd0,     16'd0,     16'd0,     1'b1, 6'd0,  6'd0,  5'd0},   // fresh after reset
    '{16'd512,   16'd256,   16'd1024,  1'b1, 6'd1,  6'd1,  5'd1},   // small step snaps
    '{16'd0,     16'd0,     16'd0,     1'b1, 6'd0,  6'd0,  5'd0},   // snap back to empty
    '{16'd25600, 16'd25600, 16'd25600, 1'b0, 6'd0,  6'd0,  5'd0},
    '{16'd25601, 16'hffff,  16'd25601, 1'b0, 6'd0,  6'd0,  5'd0},
    '{16'hffff,  16'd25601, 16'hffff,  1'b0, 6'd0,  6'd0,  5'd0},
    '{16'h8000,  16'hffff,  16'h7000,  1'b0, 6'd0,  6'd0,  5'd0},
    '{16'hffff,  16'h8000,  16'hffff,  1'b0, 6'd0,  6'd0,  5'd0},
    '{16'd25600, 16'd30000, 16'd40000, 1'b0, 6'd0,  6'd0,  5'd0},
    '{16'd50000, 16'd25600, 16'd25600, 1'b0, 6'd0,  6'd0,  5'd0},
    '{16'hffff,  16'hffff,  16'hffff,  1'b0, 6'd0,  6'd0,  5'd0},
    '{16'd25600, 16'd25600, 16'd25600, 1'b0, 6'd0,  6'd0,  5'd0},
    '{16'd60000, 16'd26000, 16'd32768, 1'b0, 6'd0,  6'd0,  5'd0},
    '{16'd25600, 16'd25600, 16'd25600, 1'b0, 6'd0,  6'd0,  5'd0},
    '{16'hffff,  16'hffff,  16'hffff,  1'b0, 6'd0,  6'd0,  5'd0},
    '{16'd25600, 16'hffff,  16'd25601, 1'b1, 6'd50, 6'd50, 5'd25},  // bars reach left edge
    '{16'd25344, 16'd25088, 16'd24832, 1'b0, 6'd0,  6'd0,  5'd0},   // partial at left edge
    '{16'h5555,  16'haaaa,  16'h00ff,  1'b0, 6'd0,  6'd0,  5'd0},
    '{16'haaaa,  16'h5555,  16'hff00,  1'b0, 6'd0,  6'd0,  5'd0},
    '{16'd0,     16'd0,     16'd0,     1'b0, 6'd0,  6'd0,  5'd0},   // large fall, rounds down
    '{16'd1,     16'd2,     16'd3,     1'b0, 6'd0,  6'd0,  5'd0},
    '{16'd384,   16'd640,   16'd768,   1'b0, 6'd0,  6'd0,  5'd0},
    '{16'd13000, 16'd6500,  16'd25600, 1'b0, 6'd0,  6'd0,  5'd0},
    '{16'd0,     16'd25600, 16'd0,     1'b0, 6'd0,  6'd0,  5'd0},
    '{16'd25600, 16'd0,     16'd12800, 1'b0, 6'd0,  6'd0,  5'd0}
  };

  smoothed_triple_bar_renderer_top #(.NUM_COLUMNS(NCOL)) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tlast(m_tlast)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Run limit, far above the slowest legal run
  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at %0t: %s got %0d want %0d", $time, what, got, want);
    errors++;
  endtask

  // Percent clipped at 100.0
  function automatic int clip_pct(input logic [stbr_pkg::PCT_W-1:0] p);
    return (p > stbr_pkg::PCT_MAX) ? int'(stbr_pkg::PCT_MAX) : int'(p);
  endfunction

  // One smoothing update: move ~0.3 of the gap, or snap when within 1.0
  function automatic int smooth_toward(input int lvl, input int tgt, input int top);
    int d;
    int nxt;
    d = tgt - lvl;
    if (d > 256) nxt = lvl + ((d * 77) >>> 8);
    else if (d < -256) nxt = lvl - (((-d) * 77 + 255) >>> 8);
    else nxt = tgt;
    if (nxt < 0) nxt = 0;
    if (nxt > top) nxt = top;
    return nxt;
  endfunction

  function automatic int bar_steps(input int lvl);
    return (lvl + 128) >>> 8;
  endfunction

  // Two-row band: full columns from the right, partial one next to them when odd
  function automatic logic [stbr_pkg::BITS_W-1:0] wide_bar(
    input int pos, input int l,
    input logic [stbr_pkg::BITS_W-1:0] full,
    input logic [stbr_pkg::BITS_W-1:0] part);
    if (pos < l / 2) return full;
    if (pos == l / 2 && l % 2 == 1) return part;
    return '0;
  endfunction

  task automatic queue_frame(input int lc, input int lr, input int lg);
    column_t col;
    int pos;
    for (int c = 0; c < NCOL; c++) begin
      pos = NCOL - 1 - c;
      col.idx  = c[stbr_pkg::IDX_W-1:0];
      col.bits = wide_bar(pos, lc, stbr_pkg::CPU_FULL, stbr_pkg::CPU_PART)
               | wide_bar(pos, lr, stbr_pkg::RAM_FULL, stbr_pkg::RAM_PART)
               | ((pos < lg) ? stbr_pkg::GPU_BIT : '0);
      col.last = (pos == 0);
      pending_columns.push_back(col);
    end
  endtask

  // Advance the predicted levels by one tick and return the step counts
  task automatic predict_tick(input tick_row_t row, output int lc, output int lr, output int lg);
    cpu_lvl = smooth_toward(cpu_lvl, clip_pct(row.cpu) / 2, int'(stbr_pkg::WIDE_MAX));
    ram_lvl = smooth_toward(ram_lvl, clip_pct(row.ram) / 2, int'(stbr_pkg::WIDE_MAX));
    gpu_lvl = smooth_toward(gpu_lvl, clip_pct(row.gpu) / 4, int'(stbr_pkg::NARROW_MAX));
    lc = bar_steps(cpu_lvl);
    lr = bar_steps(ram_lvl);
    lg = bar_steps(gpu_lvl);
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance.
  // Bursts of random length, random gaps in between.
  task automatic send_tick(input tick_row_t row);
    int lc;
    int lr;
    int lg;
    int gap;
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      gap = ($urandom_range(0, 2) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 4);
      repeat (gap) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {row.gpu, row.ram, row.cpu};
    do @(posedge clk); while (!s_tready);
    predict_tick(row, lc, lr, lg);
    if (row.known) queue_frame(row.cpu_steps, row.ram_steps, row.gpu_steps);
    else queue_frame(lc, lr, lg);
    burst_left--;
    @(negedge clk);
  endtask

  // Hold off the sender until every frame has drained
  task automatic wait_for_idle();
    s_tvalid <= 1'b0;
    while (pending_columns.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [stbr_pkg::PCT_W-1:0] pick_pct();
    case ($urandom_range(0, 4))
      0: return stbr_pkg::PCT_W'($urandom_range(0, 1024));
      1: return stbr_pkg::PCT_W'($urandom_range(24000, 25600));
      2: return stbr_pkg::PCT_W'($urandom_range(25601, 65535));
      default: return stbr_pkg::PCT_W'($urandom_range(0, 25600));
    endcase
  endfunction

  function automatic logic [stbr_pkg::PCT_W-1:0] edge_pct();
    case ($urandom_range(0, 7))
      0: return 16'd0;
      1: return 16'd1;
      2: return 16'd255;
      3: return 16'd256;
      4: return 16'd25599;
      5: return 16'd25600;
      6: return 16'd25601;
      default: return 16'hffff;
    endcase
  endfunction

  // Small wobble around a held value, kept inside 16 bits
  function automatic logic [stbr_pkg::PCT_W-1:0] wobble(input logic [stbr_pkg::PCT_W-1:0] p);
    int v;
    v = int'(p);
    if ($urandom_range(0, 2) == 0) v = v + $urandom_range(0, 1024) - 512;
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return v[stbr_pkg::PCT_W-1:0];
  endfunction

  // Receiver: stall pattern switches between modes every so often
  always @(negedge clk) begin
    if (mode_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      mode_left = $urandom_range(10, 150);
    end else begin
      mode_left--;
    end
    case (stall_mode)
      READY_ALWAYS: m_tready <= 1'b1;
      READY_COIN: m_tready <= 1'($urandom_range(0, 1));
      READY_MOSTLY: m_tready <= ($urandom_range(0, 7) != 0);
      default: m_tready <= ((mode_left % 11) < 3);
    endcase
  end

  // Column checker
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_columns.size() == 0) begin
        report_mismatch("column word with nothing pending", m_tdata, 0);
      end else begin
        want_col = pending_columns.pop_front();
        if (m_tdata[4:0] !== want_col.idx)
          report_mismatch("column_index", m_tdata[4:0], want_col.idx);
        if (m_tdata[11:5] !== want_col.bits)
          report_mismatch("column_bits", m_tdata[11:5], want_col.bits);
        if (m_tlast !== want_col.last)
          report_mismatch("last_column", m_tlast, want_col.last);
        if (m_tdata[15:12] !== 4'b0)
          report_mismatch("tdata padding", m_tdata[15:12], 0);
      end
    end
  end

  // Stimulus
  initial begin
    tick_row_t row;
    logic [stbr_pkg::PCT_W-1:0] hc;
    logic [stbr_pkg::PCT_W-1:0] hr;
    logic [stbr_pkg::PCT_W-1:0] hg;
    int sent;
    int hold;
    int kind;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < TABLE_ROWS; i++) send_tick(tick_table[i]);
    wait_for_idle();

    // Mostly held loads with wobble so the levels settle, plus noise and edge values
    sent = 0;
    while (sent < RANDOM_TICKS) begin
      if (sent >= RANDOM_TICKS / 2 && sent < RANDOM_TICKS / 2 + 12) begin
        wait_for_idle();
        sent = RANDOM_TICKS / 2 + 12;
      end
      kind = $urandom_range(0, 9);
      row = '0;
      if (kind < 7) begin
        hc = pick_pct();
        hr = pick_pct();
        hg = pick_pct();
        hold = $urandom_range(1, 12);
        for (int h = 0; h < hold; h++) begin
          row.cpu = wobble(hc);
          row.ram = wobble(hr);
          row.gpu = wobble(hg);
          send_tick(row);
          sent++;
        end
      end else if (kind < 9) begin
        row.cpu = stbr_pkg::PCT_W'($urandom());
        row.ram = stbr_pkg::PCT_W'($urandom());
        row.gpu = stbr_pkg::PCT_W'($urandom());
        send_tick(row);
        sent++;
      end else begin
        row.cpu = edge_pct();
        row.ram = edge_pct();
        row.gpu = edge_pct();
        send_tick(row);
        sent++;
      end
    end

    s_tvalid <= 1'b0;
    while (pending_columns.size() != 0) @(posedge clk);
    repeat (FLUSH_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### sim.f
hdl/stbr_pkg.sv
hdl/stbr_front.sv
hdl/stbr_queue.sv
hdl/stbr_back.sv
hdl/smoothed_triple_bar_renderer_top.sv
verif/smoothed_triple_bar_renderer_top_test.sv
